// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl of the conveyor sort controller
// expects a clock clk_i and an active low reset rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/csc_pkg.sv =====
// shared types and constants of the conveyor sort controller
// no dependencies
package csc_pkg;

  // camera result queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned QueueLevelW = 4;
  localparam int unsigned ClassW      = 2;
  localparam int unsigned HostStateW  = 3;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned JobMsW      = 16;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        RegIdxRobotJobMs = 1'b0;
  localparam logic [JobMsW-1:0] RobotJobMsReset = 16'd3000;

  // request kinds on tuser
  typedef enum logic [1:0] {
    OpExec = 2'd0,
    OpPush = 2'd1,
    OpHost = 2'd2
  } opcode_e;

  localparam logic [ClassW-1:0] ClassNone  = 2'd0;
  localparam logic [ClassW-1:0] ClassLarge = 2'd1;

  // result word, main_mode in the lowest bits
  typedef struct packed {
    logic [QueueLevelW-1:0] queue_level;
    logic [ClassW-1:0]      popped_class;
    logic                   conveyors_stopped;
    logic                   robot_start_pulse;
    logic                   robot_busy;
    logic [1:0]             sort_mode;
    logic [2:0]             main_mode;
  } result_t;

endpackage

// ===== rtl/core/conveyor_sort_controller.sv =====
// conveyor sort controller: main and sort state machines, camera result queue,
// output register with skid stage; depends on csc_pkg and assert_macros.svh
//
// The controller takes one request per clock cycle while the skid stage is
// empty and returns exactly one result per request. Every request (execution
// step, camera push or host state write) is resolved in a single pass of the
// step logic between the state registers and the result register, so the
// step logic sets the rate of one request per cycle. Results leave through
// an output register backed by a one-entry skid stage: s_axis_tready stays
// high while the output waits, and only drops once both hold a result. The
// camera queue holds eight results in flip-flops and is cleared on the first
// execution step in boot. The user must write robot_job_ms through the APB port
// only while no request is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module conveyor_sort_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_ms[31:0], robot_area_busy[32], agv_arrived[33], agv_departed[34],
  // camera_class[36:35], host_state[39:37]
  input  logic [39:0]                   s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // main_mode[2:0], sort_mode[4:3], robot_busy[5], robot_start_pulse[6],
  // conveyors_stopped[7], popped_class[9:8], queue_level[13:10]
  output logic [15:0]                   m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [csc_pkg::CfgDataW-1:0]  pwdata,
  output logic [csc_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned Depth = csc_pkg::FifoDepth;
  localparam int unsigned PtrW  = csc_pkg::FifoPtrW;
  localparam int unsigned CntW  = csc_pkg::FifoCntW;

  typedef enum logic [2:0] {
    MainBoot        = 3'd0,
    MainIdle        = 3'd1,
    MainRunning     = 3'd2,
    MainStop        = 3'd3,
    MainEmergency   = 3'd4,
    MainRobotFinish = 3'd5
  } main_e;

  typedef enum logic [1:0] {
    SortIdle    = 2'd0,
    SortRunning = 2'd1,
    SortRobot   = 2'd2
  } sort_e;

  // request fields
  logic [csc_pkg::TimeW-1:0]      now_ms;
  logic                           robot_area_busy;
  logic                           agv_arrived;
  logic                           agv_departed;
  logic [csc_pkg::ClassW-1:0]     camera_class;
  logic [csc_pkg::HostStateW-1:0] host_state;
  csc_pkg::opcode_e               opcode;

  assign now_ms          = s_axis_tdata[31:0];
  assign robot_area_busy = s_axis_tdata[32];
  assign agv_arrived     = s_axis_tdata[33];
  assign agv_departed    = s_axis_tdata[34];
  assign camera_class    = s_axis_tdata[36:35];
  assign host_state      = s_axis_tdata[39:37];
  assign opcode          = csc_pkg::opcode_e'(s_axis_tuser);

  // state
  logic [csc_pkg::JobMsW-1:0]  robot_job_ms_q;
  main_e                       main_q, main_d;
  sort_e                       sort_q, sort_d;
  logic                        init_done_q, init_done_d;
  logic                        robot_active_q, robot_active_d;
  logic [csc_pkg::TimeW-1:0]   job_start_q, job_start_d;
  logic [PtrW-1:0]             fifo_head_q, fifo_head_d;
  logic [PtrW-1:0]             fifo_tail_q, fifo_tail_d;
  logic [CntW-1:0]             fifo_count_q, fifo_count_d;
  logic [csc_pkg::ClassW-1:0]  fifo_store_q [Depth];

  // output buffering
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  csc_pkg::result_t  out_data_q, out_data_d;
  csc_pkg::result_t  skid_data_q, skid_data_d;
  csc_pkg::result_t  result;

  logic                       in_fire;
  logic                       push_en;
  logic                       pulse;
  logic                       stopped;
  logic [csc_pkg::ClassW-1:0] popped;
  logic [csc_pkg::ClassW-1:0] head_class;
  logic [csc_pkg::TimeW-1:0]  elapsed;
  logic                       job_done;
  logic [PtrW-1:0]            head_inc;
  logic [PtrW-1:0]            tail_inc;
  logic                       cfg_write;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // wrapping job timer
  assign elapsed  = now_ms - job_start_q;
  assign job_done = elapsed >= {{(csc_pkg::TimeW - csc_pkg::JobMsW){1'b0}}, robot_job_ms_q};

  assign head_inc   = (fifo_head_q == PtrW'(Depth - 1)) ? '0 : fifo_head_q + 1'b1;
  assign tail_inc   = (fifo_tail_q == PtrW'(Depth - 1)) ? '0 : fifo_tail_q + 1'b1;
  assign head_class = fifo_store_q[fifo_head_q];

  always_comb begin
    main_d         = main_q;
    sort_d         = sort_q;
    init_done_d    = init_done_q;
    robot_active_d = robot_active_q;
    job_start_d    = job_start_q;
    fifo_head_d    = fifo_head_q;
    fifo_tail_d    = fifo_tail_q;
    fifo_count_d   = fifo_count_q;
    push_en        = 1'b0;
    pulse          = 1'b0;
    stopped        = 1'b0;
    popped         = csc_pkg::ClassNone;

    case (opcode)
      csc_pkg::OpPush: begin
        if (fifo_count_q < CntW'(Depth)) begin
          push_en      = 1'b1;
          fifo_tail_d  = tail_inc;
          fifo_count_d = fifo_count_q + 1'b1;
        end
      end
      csc_pkg::OpHost: begin
        // host states past robot finish are ignored
        if (host_state <= MainRobotFinish) begin
          main_d = main_e'(host_state);
        end
      end
      csc_pkg::OpExec: begin
        case (main_q)
          MainBoot: begin
            if (!init_done_q) begin
              fifo_head_d    = '0;
              fifo_tail_d    = '0;
              fifo_count_d   = '0;
              pulse          = 1'b1;
              robot_active_d = 1'b0;
              init_done_d    = 1'b1;
            end
          end
          MainStop, MainEmergency: begin
            stopped = 1'b1;
            main_d  = robot_active_q ? MainRobotFinish : MainIdle;
          end
          MainRobotFinish: begin
            if (job_done) begin
              robot_active_d = 1'b0;
              main_d         = MainIdle;
            end
          end
          MainRunning: begin
            case (sort_q)
              SortIdle: begin
                if (agv_arrived) begin
                  sort_d = SortRunning;
                end
              end
              SortRunning: begin
                if (!robot_area_busy && fifo_count_q != '0) begin
                  popped       = head_class;
                  fifo_head_d  = head_inc;
                  fifo_count_d = fifo_count_q - 1'b1;
                  if (head_class == csc_pkg::ClassLarge) begin
                    pulse          = 1'b1;
                    robot_active_d = 1'b1;
                    job_start_d    = now_ms;
                    sort_d         = SortRobot;
                  end
                end
                // departure wins over a job start in the same step
                if (agv_departed) begin
                  sort_d = SortIdle;
                end
              end
              SortRobot: begin
                if (job_done) begin
                  robot_active_d = 1'b0;
                  sort_d         = SortRunning;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result.main_mode         = main_d;
    result.sort_mode         = sort_d;
    result.robot_busy        = robot_active_d;
    result.robot_start_pulse = pulse;
    result.conveyors_stopped = stopped;
    result.popped_class      = popped;
    result.queue_level       = csc_pkg::QueueLevelW'(fifo_count_d);
  end

  // output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_data_d  = result;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_data_d  = result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - $bits(csc_pkg::result_t)){1'b0}}, out_data_q};

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == csc_pkg::RegIdxRobotJobMs);

  always_comb begin
    prdata = '0;
    if (paddr[2] == csc_pkg::RegIdxRobotJobMs) begin
      prdata = {{(csc_pkg::CfgDataW - csc_pkg::JobMsW){1'b0}}, robot_job_ms_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_job_ms_q <= csc_pkg::RobotJobMsReset;
      main_q         <= MainBoot;
      sort_q         <= SortIdle;
      init_done_q    <= 1'b0;
      robot_active_q <= 1'b0;
      job_start_q    <= '0;
      fifo_head_q    <= '0;
      fifo_tail_q    <= '0;
      fifo_count_q   <= '0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      if (cfg_write) begin
        robot_job_ms_q <= pwdata[csc_pkg::JobMsW-1:0];
      end
      if (in_fire) begin
        main_q         <= main_d;
        sort_q         <= sort_d;
        init_done_q    <= init_done_d;
        robot_active_q <= robot_active_d;
        job_start_q    <= job_start_d;
        fifo_head_q    <= fifo_head_d;
        fifo_tail_q    <= fifo_tail_d;
        fifo_count_q   <= fifo_count_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
    if (in_fire && push_en) begin
      fifo_store_q[fifo_tail_q] <= camera_class;
    end
  end

  `CSC_ASSERT(a_count_bound, fifo_count_q <= CntW'(Depth), "queue count past depth")
  `CSC_ASSERT(a_ptr_match, (fifo_count_q == '0 || fifo_count_q == CntW'(Depth)) == (fifo_head_q == fifo_tail_q), "queue pointers disagree with count")
  `CSC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds a result ahead of the output register")
  `CSC_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled while output was free")
  `CSC_ASSERT(a_init_sticky, init_done_q |=> init_done_q, "init done cleared after boot")

endmodule

// ===== sim/tb_conveyor_sort_controller.sv =====
// self-checking bench for conveyor_sort_controller: drives the request stream and
// the apb port, predicts each status result and checks it field by field
// depends on csc_pkg and the controller rtl
module tb_conveyor_sort_controller;

  typedef enum logic [2:0] {
    MainBoot, MainIdle, MainRunning, MainStop, MainEmergency, MainRobotFinish
  } main_e;

  typedef enum logic [1:0] {
    SortIdle, SortRunning, SortRobot
  } sort_e;

  localparam logic [1:0]                   OpUndef     = 2'd3;
  localparam logic [2:0]                   HostUndefLo = 3'd6;
  localparam logic [2:0]                   HostUndefHi = 3'd7;
  localparam logic [csc_pkg::ClassW-1:0]   ClassOtherA = 2'd2;
  localparam logic [csc_pkg::ClassW-1:0]   ClassOtherB = 2'd3;
  localparam logic [csc_pkg::CfgAddrW-1:0] AddrRobotJobMs = {csc_pkg::RegIdxRobotJobMs, 2'b00};
  localparam logic [31:0]                  WrapBase    = 32'hFFFF_FE00;
  localparam int unsigned                  StallLimit  = 2000;
  localparam int unsigned                  HoldCycles  = 80;

  typedef struct {
    logic [1:0]                 opcode;
    logic [csc_pkg::TimeW-1:0]  now_ms;
    logic                       area_busy;
    logic                       agv_arrived;
    logic                       agv_departed;
    logic [csc_pkg::ClassW-1:0] camera_class;
    logic [2:0]                 host_state;
  } step_req_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [39:0]                  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [15:0]                  m_axis_tdata;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [csc_pkg::CfgAddrW-1:0] paddr = '0;
  logic [csc_pkg::CfgDataW-1:0] pwdata = '0;
  logic [csc_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  always #4 clk_i = ~clk_i;

  conveyor_sort_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // controller state as the bench sees it
  main_e                           main_q = MainBoot;
  sort_e                           sort_q = SortIdle;
  logic                            booted = 1'b0;
  logic                            robot_on = 1'b0;
  logic [csc_pkg::TimeW-1:0]       job_t0 = '0;
  logic [csc_pkg::JobMsW-1:0]      job_ms_cfg = csc_pkg::RobotJobMsReset;
  logic [csc_pkg::ClassW-1:0]      fifo_mem [csc_pkg::FifoDepth];
  logic [csc_pkg::FifoPtrW-1:0]    fifo_wr = '0;
  logic [csc_pkg::FifoPtrW-1:0]    fifo_rd = '0;
  logic [csc_pkg::QueueLevelW-1:0] fifo_cnt = '0;

  csc_pkg::result_t          status_q [$];
  csc_pkg::result_t          got_res;
  csc_pkg::result_t          want_res;
  int unsigned               n_errors = 0;
  logic [csc_pkg::TimeW-1:0] clock_ms = '0;
  logic                      idle_en = 1'b1;
  logic                      tx_gaps_en = 1'b1;
  logic                      tx_offering = 1'b0;
  int unsigned               rx_hold_req = 0;
  int unsigned               rx_hold_left = 0;
  int unsigned               rx_gap_left = 0;
  int unsigned               stall_cnt = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 40) begin
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic logic job_done(logic [csc_pkg::TimeW-1:0] now);
    return (now - job_t0) >= {16'd0, job_ms_cfg};
  endfunction

  // advances the bench state by one accepted request and queues its status
  function automatic void predict_status(step_req_t r);
    csc_pkg::result_t           res;
    logic [csc_pkg::ClassW-1:0] popped;
    logic                       pulse;
    logic                       halted;
    popped = csc_pkg::ClassNone;
    pulse  = 1'b0;
    halted = 1'b0;
    case (r.opcode)
      csc_pkg::OpPush: begin
        if (fifo_cnt < csc_pkg::FifoDepth) begin
          fifo_mem[fifo_wr] = r.camera_class;
          fifo_wr++;
          fifo_cnt++;
        end
      end
      csc_pkg::OpHost: begin
        if (r.host_state <= MainRobotFinish) main_q = main_e'(r.host_state);
      end
      csc_pkg::OpExec: begin
        case (main_q)
          MainBoot: begin
            if (!booted) begin
              fifo_wr  = '0;
              fifo_rd  = '0;
              fifo_cnt = '0;
              pulse    = 1'b1;
              robot_on = 1'b0;
              booted   = 1'b1;
            end
          end
          MainStop, MainEmergency: begin
            halted = 1'b1;
            main_q = robot_on ? MainRobotFinish : MainIdle;
          end
          MainRobotFinish: begin
            if (job_done(r.now_ms)) begin
              robot_on = 1'b0;
              main_q   = MainIdle;
            end
          end
          MainRunning: begin
            case (sort_q)
              SortIdle: begin
                if (r.agv_arrived) sort_q = SortRunning;
              end
              SortRunning: begin
                if (!r.area_busy && fifo_cnt != 0) begin
                  popped = fifo_mem[fifo_rd];
                  fifo_rd++;
                  fifo_cnt--;
                  if (popped == csc_pkg::ClassLarge) begin
                    pulse    = 1'b1;
                    robot_on = 1'b1;
                    job_t0   = r.now_ms;
                    sort_q   = SortRobot;
                  end
                end
                // departure wins over a job started in the same step
                if (r.agv_departed) sort_q = SortIdle;
              end
              SortRobot: begin
                if (job_done(r.now_ms)) begin
                  robot_on = 1'b0;
                  sort_q   = SortRunning;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.main_mode         = main_q;
    res.sort_mode         = sort_q;
    res.robot_busy        = robot_on;
    res.robot_start_pulse = pulse;
    res.conveyors_stopped = halted;
    res.popped_class      = popped;
    res.queue_level       = fifo_cnt;
    status_q.push_back(res);
  endfunction

  task automatic send_request(step_req_t r);
    if (tx_gaps_en && idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.host_state, r.camera_class, r.agv_departed, r.agv_arrived,
                      r.area_busy, r.now_ms};
    s_axis_tuser  <= r.opcode;
    tx_offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_status(r);
  endtask

  task automatic send_step(input logic [1:0] op, input logic [csc_pkg::TimeW-1:0] now,
                           input logic busy, input logic arr, input logic dep,
                           input logic [csc_pkg::ClassW-1:0] cls, input logic [2:0] host);
    step_req_t r;
    r.opcode       = op;
    r.now_ms       = now;
    r.area_busy    = busy;
    r.agv_arrived  = arr;
    r.agv_departed = dep;
    r.camera_class = cls;
    r.host_state   = host;
    send_request(r);
  endtask

  // mostly well-formed traffic: enough exec steps and running requests to keep
  // the sort machine busy, with occasional jumps of the timestamp
  function automatic step_req_t random_request();
    step_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, job_ms_cfg / 3 + 4);
    r.now_ms       = clock_ms;
    r.area_busy    = ($urandom_range(0, 3) == 0);
    r.agv_arrived  = ($urandom_range(0, 2) == 0);
    r.agv_departed = ($urandom_range(0, 11) == 0);
    r.camera_class = ($urandom_range(0, 2) == 0) ? csc_pkg::ClassLarge :
                     csc_pkg::ClassW'($urandom_range(0, 3));
    r.host_state   = 3'($urandom_range(0, 7));
    if (pick < 50) begin
      r.opcode = csc_pkg::OpExec;
    end else if (pick < 75) begin
      r.opcode = csc_pkg::OpPush;
    end else if (pick < 97) begin
      r.opcode = csc_pkg::OpHost;
      if ($urandom_range(0, 1) == 0) r.host_state = MainRunning;
    end else begin
      r.opcode = OpUndef;
    end
    return r;
  endfunction

  task automatic wait_for_results();
    if (tx_offering) begin
      s_axis_tvalid <= 1'b0;
      tx_offering = 1'b0;
    end
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [csc_pkg::CfgAddrW-1:0] addr,
                           input logic [csc_pkg::CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic apb_read(input logic [csc_pkg::CfgAddrW-1:0] addr,
                          output logic [csc_pkg::CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
  endtask

  task automatic verify_job_time();
    logic [csc_pkg::CfgDataW-1:0] rd;
    apb_read(AddrRobotJobMs, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    compare_field("robot_job_ms readback", rd, {16'd0, job_ms_cfg});
  endtask

  task automatic program_job_time(logic [csc_pkg::JobMsW-1:0] ms);
    wait_for_results();
    apb_write(AddrRobotJobMs, {16'd0, ms});
    job_ms_cfg = ms;
    verify_job_time();
  endtask

  task automatic test_directed_cases();
    verify_job_time();
    send_step(csc_pkg::OpPush, 32'd0, 1'b0, 1'b0, 1'b0, csc_pkg::ClassLarge, MainBoot);
    // first exec in boot clears the queue and fires the robot
    send_step(csc_pkg::OpExec, 32'd0, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, 32'd0, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(OpUndef, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, ClassOtherB, HostUndefHi);
    send_step(csc_pkg::OpHost, 32'd5, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, HostUndefHi);
    send_step(csc_pkg::OpHost, 32'd5, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, HostUndefLo);
    send_step(csc_pkg::OpHost, 32'd5, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainRunning);
    send_step(csc_pkg::OpExec, 32'd10, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, 32'd11, 1'b0, 1'b1, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpPush, 32'd12, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpPush, 32'd12, 1'b0, 1'b0, 1'b0, csc_pkg::ClassLarge, MainBoot);
    send_step(csc_pkg::OpPush, 32'd12, 1'b0, 1'b0, 1'b0, ClassOtherA, MainBoot);
    send_step(csc_pkg::OpPush, 32'd12, 1'b0, 1'b0, 1'b0, ClassOtherB, MainBoot);
    send_step(csc_pkg::OpExec, 32'd13, 1'b1, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, 32'd14, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    // large pop together with a departure, timer set to wrap
    send_step(csc_pkg::OpExec, WrapBase, 1'b0, 1'b0, 1'b1, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpHost, WrapBase, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone,
              MainEmergency);
    send_step(csc_pkg::OpExec, WrapBase, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, WrapBase + csc_pkg::RobotJobMsReset - 1, 1'b0, 1'b0, 1'b0,
              csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, WrapBase + csc_pkg::RobotJobMsReset, 1'b0, 1'b0, 1'b0,
              csc_pkg::ClassNone, MainBoot);
    // overfill the queue so the last push is dropped
    for (int i = 0; i < 7; i++) begin
      send_step(csc_pkg::OpPush, 32'd20, 1'b0, 1'b0, 1'b0,
                csc_pkg::ClassW'($urandom_range(0, 3)), MainBoot);
    end
  endtask

  task automatic test_zero_job_time();
    program_job_time(16'd0);
    send_step(csc_pkg::OpHost, 32'd100, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainRunning);
    send_step(csc_pkg::OpExec, 32'd100, 1'b0, 1'b1, 1'b0, csc_pkg::ClassNone, MainBoot);
    for (int i = 0; i < 9; i++) begin
      send_step(csc_pkg::OpExec, 32'd100, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    end
    send_step(csc_pkg::OpPush, 32'd100, 1'b0, 1'b0, 1'b0, csc_pkg::ClassLarge, MainBoot);
    send_step(csc_pkg::OpExec, 32'd100, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
    send_step(csc_pkg::OpExec, 32'd100, 1'b0, 1'b0, 1'b0, csc_pkg::ClassNone, MainBoot);
  endtask

  task automatic test_random_traffic(logic [csc_pkg::JobMsW-1:0] ms, int unsigned n_items);
    program_job_time(ms);
    clock_ms = $urandom();
    repeat (n_items) send_request(random_request());
  endtask

  // receiver holds off while requests keep coming, so the input must stall
  task automatic test_output_backpressure();
    wait_for_results();
    tx_gaps_en  = 1'b0;
    rx_hold_req = HoldCycles;
    repeat (40) send_request(random_request());
    tx_gaps_en = 1'b1;
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      rx_gap_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unrequested result", 32'(m_axis_tdata), 32'd0);
      end else begin
        got_res  = csc_pkg::result_t'(m_axis_tdata[13:0]);
        want_res = status_q.pop_front();
        compare_field("main_mode", 32'(got_res.main_mode), 32'(want_res.main_mode));
        compare_field("sort_mode", 32'(got_res.sort_mode), 32'(want_res.sort_mode));
        compare_field("robot_busy", 32'(got_res.robot_busy), 32'(want_res.robot_busy));
        compare_field("robot_start_pulse", 32'(got_res.robot_start_pulse),
                      32'(want_res.robot_start_pulse));
        compare_field("conveyors_stopped", 32'(got_res.conveyors_stopped),
                      32'(want_res.conveyors_stopped));
        compare_field("popped_class", 32'(got_res.popped_class),
                      32'(want_res.popped_class));
        compare_field("queue_level", 32'(got_res.queue_level),
                      32'(want_res.queue_level));
        compare_field("tdata padding", 32'(m_axis_tdata[15:14]), 32'd0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_zero_job_time();
    test_random_traffic(16'd1, 360);
    test_random_traffic(16'hFFFF, 360);
    test_random_traffic(csc_pkg::JobMsW'($urandom_range(2, 65534)), 360);
    test_output_backpressure();
    idle_en = 1'b0;
    test_random_traffic(csc_pkg::RobotJobMsReset, 200);
    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
